// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion clocked on aclk
// and disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of aclk outside reset.
`define ARCN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("arc_center_normalize check failed");

`endif

// ===== design/arcn_pkg.sv =====
// ----------------------------------------------------------------------------
// arcn_pkg: shared types and constants
// Operation and status codes, datapath widths and the per-item side record
// that travels alongside the square-root and divider cell chains.
// ----------------------------------------------------------------------------
package arcn_pkg;

    // Fraction bits of the Q format; sets the half-unit mismatch tolerance.
    localparam int FRAC_BITS = 16;

    // Square-root chain: 66-bit radicand, 33-bit root, one root bit per cell.
    localparam int SQ_VAL_W  = 66;
    localparam int SQ_ROOT_W = 33;
    localparam int SQ_REM_W  = 36;
    localparam int SQ_STAGES = SQ_ROOT_W;

    // Divider chain: 64-bit dividend, 32-bit divisor, one quotient bit per cell.
    localparam int DV_NUM_W  = 64;
    localparam int DV_DEN_W  = 32;
    localparam int DV_STAGES = DV_NUM_W;

    // Perpendicular term is clamped to 2^TERM_CAP_BIT.
    localparam int TERM_CAP_BIT = 40;

    typedef enum logic [1:0] {
        OP_PLAIN  = 2'd0,
        OP_RADIUS = 2'd1,
        OP_CENTER = 2'd2,
        OP_SPARE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SHORT      = 2'd1,
        ST_MISMATCH   = 2'd2,
        ST_ZERO_CHORD = 2'd3
    } status_t;

    // Per-item record that rides along with the arithmetic cells.
    typedef struct packed {
        op_t                op;
        status_t            status;
        logic               calc;
        logic               neg_ty;
        logic               neg_tx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] ci;
        logic signed [31:0] cj;
        logic signed [31:0] ro;
        logic [31:0]        ax;
        logic [31:0]        ay;
    } side_t;

endpackage

// ===== design/arcn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// arcn_sqrt_cell: one step of a digit-by-digit square root
// Brings down two radicand bits, tries the next root bit and registers the
// partial root, the remainder and the shifted radicand for the next cell.
// ----------------------------------------------------------------------------
module arcn_sqrt_cell import arcn_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [SQ_VAL_W-1:0]  val_i,
    input  logic [SQ_REM_W-1:0]  rem_i,
    input  logic [SQ_ROOT_W-1:0] root_i,
    output logic [SQ_VAL_W-1:0]  val_o,
    output logic [SQ_REM_W-1:0]  rem_o,
    output logic [SQ_ROOT_W-1:0] root_o
);

    logic [SQ_VAL_W-1:0]  val_reg;
    logic [SQ_REM_W-1:0]  rem_reg;
    logic [SQ_ROOT_W-1:0] root_reg;
    logic [SQ_REM_W-1:0]  rem_sh;
    logic [SQ_REM_W-1:0]  trial;
    logic                 take;

    // Trial subtraction of (4*root + 1) from the shifted remainder.
    always_comb begin
        rem_sh = {rem_i[SQ_REM_W-3:0], val_i[SQ_VAL_W-1 -: 2]};
        trial  = {1'b0, root_i, 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg  <= {val_i[SQ_VAL_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_i[SQ_ROOT_W-2:0], take};
        end
    end

    assign val_o  = val_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;

endmodule

// ===== design/arcn_div_cell.sv =====
// ----------------------------------------------------------------------------
// arcn_div_cell: one step of a restoring divider
// Shifts one dividend bit into the remainder, subtracts the divisor when it
// fits and shifts the quotient bit in where the dividend bit left.
// ----------------------------------------------------------------------------
module arcn_div_cell import arcn_pkg::*; (
    input  logic                aclk,
    input  logic                en,
    input  logic [DV_NUM_W-1:0] nq_i,
    input  logic [DV_DEN_W-1:0] rem_i,
    input  logic [DV_DEN_W-1:0] den_i,
    output logic [DV_NUM_W-1:0] nq_o,
    output logic [DV_DEN_W-1:0] rem_o,
    output logic [DV_DEN_W-1:0] den_o
);

    logic [DV_NUM_W-1:0] nq_reg;
    logic [DV_DEN_W-1:0] rem_reg;
    logic [DV_DEN_W-1:0] den_reg;
    logic [DV_DEN_W:0]   part;
    logic [DV_DEN_W:0]   diff;
    logic                take;

    // Partial remainder compare and subtract.
    always_comb begin
        part = {rem_i, nq_i[DV_NUM_W-1]};
        diff = part - {1'b0, den_i};
        take = (part >= {1'b0, den_i});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg  <= {nq_i[DV_NUM_W-2:0], take};
            rem_reg <= take ? diff[DV_DEN_W-1:0] : part[DV_DEN_W-1:0];
            den_reg <= den_i;
        end
    end

    assign nq_o  = nq_reg;
    assign rem_o = rem_reg;
    assign den_o = den_reg;

endmodule

// ===== design/arc_center_normalize.sv =====
// ----------------------------------------------------------------------------
// arc_center_normalize: arc move to center-offset-plus-radius form
// Radius mode derives the center from the chord; center mode derives and
// checks the radius; plain moves pass through. Signed fixed point throughout.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_*       input      s_valid / s_ready    operation, direction, target,
//                                            radius, center offsets
//  m_*       output     m_valid / m_ready    center_i, center_j, radius, status
//
// One item is accepted per cycle while the pipeline advances; each result
// passes through the 33-cell square-root chain and the 64-cell divider
// chain. The whole pipeline advances together whenever the output
// register is empty or being drained, so s_ready follows m_ready while a
// result is held. Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module arc_center_normalize import arcn_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic               s_counter_clockwise,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_radius_in,
    input  logic signed [31:0] s_offset_i,
    input  logic signed [31:0] s_offset_j,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_center_i,
    output logic signed [31:0] m_center_j,
    output logic signed [31:0] m_radius_out,
    output logic [1:0]         m_status
);

    localparam int NSTG = 3 + SQ_STAGES + 2 + DV_STAGES + 2;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] n;
        n = v[32] ? (~v + 33'd1) : v;
        return n[31:0];
    endfunction

    function automatic logic signed [31:0] sat44(input logic signed [43:0] v);
        logic signed [31:0] r;
        if (v > 44'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -44'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic                en;
    logic [NSTG-1:0]     pipe_vld_reg;
    logic [NSTG-1:0]     pipe_vld_next;

    // Stage 1: magnitudes
    logic [31:0]         s1_m_reg [4];
    logic [31:0]         s1_mr_reg;
    side_t               s1_sd_reg;
    logic [31:0]         s1_m_next [4];
    side_t               s1_sd_next;

    // Stage 2: squares
    logic [63:0]         s2_p_reg [4];
    logic [63:0]         s2_pr_reg;
    side_t               s2_sd_reg;

    // Stage 3: radicands
    logic [SQ_VAL_W-1:0] s3_va_reg;
    logic [SQ_VAL_W-1:0] s3_vb_reg;
    side_t               s3_sd_reg;
    logic [SQ_VAL_W-1:0] s3_va_next;
    logic [SQ_VAL_W-1:0] s3_vb_next;
    side_t               s3_sd_next;

    // Square-root chains
    logic [SQ_VAL_W-1:0]  sqa_val  [SQ_STAGES+1];
    logic [SQ_REM_W-1:0]  sqa_rem  [SQ_STAGES+1];
    logic [SQ_ROOT_W-1:0] sqa_root [SQ_STAGES+1];
    logic [SQ_VAL_W-1:0]  sqb_val  [SQ_STAGES+1];
    logic [SQ_REM_W-1:0]  sqb_rem  [SQ_STAGES+1];
    logic [SQ_ROOT_W-1:0] sqb_root [SQ_STAGES+1];
    side_t                sq_sd_reg [SQ_STAGES];

    // Stage M1 and M2: products and dividends
    logic [63:0]         m1_py_reg;
    logic [63:0]         m1_px_reg;
    logic [31:0]         m1_d_reg;
    logic [32:0]         m1_delta_reg;
    logic [32:0]         m1_rr_reg;
    side_t               m1_sd_reg;
    logic [SQ_ROOT_W-1:0] root_a;
    logic [SQ_ROOT_W-1:0] root_b;

    logic [63:0]         m2_ny_reg;
    logic [63:0]         m2_nx_reg;
    logic [31:0]         m2_d_reg;
    side_t               m2_sd_reg;
    side_t               m2_sd_next;

    // Divider chains
    logic [DV_NUM_W-1:0] dy_nq  [DV_STAGES+1];
    logic [DV_DEN_W-1:0] dy_rem [DV_STAGES+1];
    logic [DV_DEN_W-1:0] dy_den [DV_STAGES+1];
    logic [DV_NUM_W-1:0] dx_nq  [DV_STAGES+1];
    logic [DV_DEN_W-1:0] dx_rem [DV_STAGES+1];
    logic [DV_DEN_W-1:0] dx_den [DV_STAGES+1];
    side_t               dv_sd_reg [DV_STAGES];

    // Final stages
    logic signed [42:0]  f1_vi_reg;
    logic signed [42:0]  f1_vj_reg;
    side_t               f1_sd_reg;
    logic [TERM_CAP_BIT:0] cap_y;
    logic [TERM_CAP_BIT:0] cap_x;
    logic signed [42:0]  ty_s;
    logic signed [42:0]  tx_s;
    logic signed [43:0]  hi_i;
    logic signed [43:0]  hi_j;

    logic signed [31:0]  out_ci_reg;
    logic signed [31:0]  out_cj_reg;
    logic signed [31:0]  out_ro_reg;
    logic [1:0]          out_st_reg;

    // Global advance: the pipeline moves when the output slot frees up.
    assign en      = !pipe_vld_reg[NSTG-1] || m_ready;
    assign s_ready = en;
    assign m_valid = pipe_vld_reg[NSTG-1];

    assign pipe_vld_next = {pipe_vld_reg[NSTG-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_vld_reg <= '0;
        end else if (en) begin
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    // Stage 1: operand magnitudes and sign bookkeeping.
    always_comb begin
        logic hpos;
        logic [31:0] ar;
        hpos = s_counter_clockwise ^ s_radius_in[31];
        ar   = mag32(s_radius_in);
        s1_sd_next        = '0;
        s1_sd_next.op     = op_t'(s_operation);
        s1_sd_next.status = ST_OK;
        s1_sd_next.neg_ty = s_target_y[31] ^ ~hpos;
        s1_sd_next.neg_tx = s_target_x[31] ^ ~hpos;
        s1_sd_next.x      = s_target_x;
        s1_sd_next.y      = s_target_y;
        s1_sd_next.ci     = s_offset_i;
        s1_sd_next.cj     = s_offset_j;
        s1_sd_next.ax     = mag32(s_target_x);
        s1_sd_next.ay     = mag32(s_target_y);
        s1_sd_next.ro     = s_radius_in;
        if (op_t'(s_operation) == OP_RADIUS) begin
            s1_sd_next.ro = (ar == 32'h80000000) ? 32'sh7fffffff : ar;
        end
        if (op_t'(s_operation) == OP_CENTER) begin
            s1_m_next[0] = mag33({s_target_x[31], s_target_x} - {s_offset_i[31], s_offset_i});
            s1_m_next[1] = mag33({s_target_y[31], s_target_y} - {s_offset_j[31], s_offset_j});
        end else begin
            s1_m_next[0] = mag32(s_target_x);
            s1_m_next[1] = mag32(s_target_y);
        end
        s1_m_next[2] = mag32(s_offset_i);
        s1_m_next[3] = mag32(s_offset_j);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_m_reg  <= s1_m_next;
            s1_mr_reg <= mag32(s_radius_in);
            s1_sd_reg <= s1_sd_next;
        end
    end

    // Stage 2: squares, one multiplier each.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                s2_p_reg[k] <= {32'd0, s1_m_reg[k]} * {32'd0, s1_m_reg[k]};
            end
            s2_pr_reg <= {32'd0, s1_mr_reg} * {32'd0, s1_mr_reg};
            s2_sd_reg <= s1_sd_reg;
        end
    end

    // Stage 3: radicands and the early radius-mode checks.
    always_comb begin
        logic [64:0] suma;
        logic [65:0] fourr;
        logic [63:0] hdiff;
        suma  = {1'b0, s2_p_reg[0]} + {1'b0, s2_p_reg[1]};
        fourr = {s2_pr_reg, 2'b00};
        hdiff = fourr[63:0] - suma[63:0];
        s3_sd_next = s2_sd_reg;
        s3_va_next = {1'b0, suma};
        if (s2_sd_reg.op == OP_RADIUS) begin
            s3_vb_next = {2'b00, hdiff};
            if (suma == '0) begin
                s3_sd_next.status = ST_ZERO_CHORD;
                s3_sd_next.ci     = '0;
                s3_sd_next.cj     = '0;
            end else if (fourr < {1'b0, suma}) begin
                s3_sd_next.status = ST_SHORT;
                s3_sd_next.ci     = '0;
                s3_sd_next.cj     = '0;
            end else begin
                s3_sd_next.calc = 1'b1;
            end
        end else begin
            s3_vb_next = {1'b0, {1'b0, s2_p_reg[2]} + {1'b0, s2_p_reg[3]}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_va_reg <= s3_va_next;
            s3_vb_reg <= s3_vb_next;
            s3_sd_reg <= s3_sd_next;
        end
    end

    // Two square-root chains: A the chord or distance, B the offset or height.
    assign sqa_val[0]  = s3_va_reg;
    assign sqa_rem[0]  = '0;
    assign sqa_root[0] = '0;
    assign sqb_val[0]  = s3_vb_reg;
    assign sqb_rem[0]  = '0;
    assign sqb_root[0] = '0;

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
        arcn_sqrt_cell u_sqa (
            .aclk   (aclk),
            .en     (en),
            .val_i  (sqa_val[g]),
            .rem_i  (sqa_rem[g]),
            .root_i (sqa_root[g]),
            .val_o  (sqa_val[g+1]),
            .rem_o  (sqa_rem[g+1]),
            .root_o (sqa_root[g+1])
        );
        arcn_sqrt_cell u_sqb (
            .aclk   (aclk),
            .en     (en),
            .val_i  (sqb_val[g]),
            .rem_i  (sqb_rem[g]),
            .root_i (sqb_root[g]),
            .val_o  (sqb_val[g+1]),
            .rem_o  (sqb_rem[g+1]),
            .root_o (sqb_root[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_sd_reg[0] <= s3_sd_reg;
            for (int k = 1; k < SQ_STAGES; k++) begin
                sq_sd_reg[k] <= sq_sd_reg[k-1];
            end
        end
    end

    // Stage M1: offset products and the center-mode radius difference.
    assign root_a = sqa_root[SQ_STAGES];
    assign root_b = sqb_root[SQ_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_py_reg    <= {32'd0, sq_sd_reg[SQ_STAGES-1].ay} * {32'd0, root_b[31:0]};
            m1_px_reg    <= {32'd0, sq_sd_reg[SQ_STAGES-1].ax} * {32'd0, root_b[31:0]};
            m1_d_reg     <= root_a[31:0];
            m1_delta_reg <= (root_a > root_b) ? (root_a - root_b) : (root_b - root_a);
            m1_rr_reg    <= root_b;
            m1_sd_reg    <= sq_sd_reg[SQ_STAGES-1];
        end
    end

    // Stage M2: rounding bias on the dividends and the center-mode verdict.
    always_comb begin
        m2_sd_next = m1_sd_reg;
        if (m1_sd_reg.op == OP_CENTER) begin
            if ((m1_delta_reg >= 33'(1 << (FRAC_BITS - 1)))
                    || (43'(m1_delta_reg) * 43'd1000 >= 43'(m1_rr_reg))) begin
                m2_sd_next.status = ST_MISMATCH;
            end
            m2_sd_next.ro = (m1_rr_reg[32:31] != 2'b00) ? 32'sh7fffffff
                                                        : m1_rr_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_ny_reg <= m1_py_reg + {33'd0, m1_d_reg[31:1]};
            m2_nx_reg <= m1_px_reg + {33'd0, m1_d_reg[31:1]};
            m2_d_reg  <= m1_d_reg;
            m2_sd_reg <= m2_sd_next;
        end
    end

    // Two divider chains sharing the chord length as divisor.
    assign dy_nq[0]  = m2_ny_reg;
    assign dy_rem[0] = '0;
    assign dy_den[0] = m2_d_reg;
    assign dx_nq[0]  = m2_nx_reg;
    assign dx_rem[0] = '0;
    assign dx_den[0] = m2_d_reg;

    for (genvar g = 0; g < DV_STAGES; g++) begin : g_dv
        arcn_div_cell u_dy (
            .aclk  (aclk),
            .en    (en),
            .nq_i  (dy_nq[g]),
            .rem_i (dy_rem[g]),
            .den_i (dy_den[g]),
            .nq_o  (dy_nq[g+1]),
            .rem_o (dy_rem[g+1]),
            .den_o (dy_den[g+1])
        );
        arcn_div_cell u_dx (
            .aclk  (aclk),
            .en    (en),
            .nq_i  (dx_nq[g]),
            .rem_i (dx_rem[g]),
            .den_i (dx_den[g]),
            .nq_o  (dx_nq[g+1]),
            .rem_o (dx_rem[g+1]),
            .den_o (dx_den[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_sd_reg[0] <= m2_sd_reg;
            for (int k = 1; k < DV_STAGES; k++) begin
                dv_sd_reg[k] <= dv_sd_reg[k-1];
            end
        end
    end

    // Stage F1: clamp the quotients, apply signs, form the doubled center.
    always_comb begin
        logic [DV_NUM_W-1:0] qy;
        logic [DV_NUM_W-1:0] qx;
        qy = dy_nq[DV_STAGES];
        qx = dx_nq[DV_STAGES];
        if ((qy[DV_NUM_W-1:TERM_CAP_BIT+1] != '0)
                || (qy[TERM_CAP_BIT] && (qy[TERM_CAP_BIT-1:0] != '0))) begin
            cap_y = {1'b1, {TERM_CAP_BIT{1'b0}}};
        end else begin
            cap_y = qy[TERM_CAP_BIT:0];
        end
        if ((qx[DV_NUM_W-1:TERM_CAP_BIT+1] != '0)
                || (qx[TERM_CAP_BIT] && (qx[TERM_CAP_BIT-1:0] != '0))) begin
            cap_x = {1'b1, {TERM_CAP_BIT{1'b0}}};
        end else begin
            cap_x = qx[TERM_CAP_BIT:0];
        end
        ty_s = dv_sd_reg[DV_STAGES-1].neg_ty ? -$signed({2'b00, cap_y})
                                              : $signed({2'b00, cap_y});
        tx_s = dv_sd_reg[DV_STAGES-1].neg_tx ? -$signed({2'b00, cap_x})
                                              : $signed({2'b00, cap_x});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_vi_reg <= 43'(dv_sd_reg[DV_STAGES-1].x) - ty_s;
            f1_vj_reg <= 43'(dv_sd_reg[DV_STAGES-1].y) + tx_s;
            f1_sd_reg <= dv_sd_reg[DV_STAGES-1];
        end
    end

    // Output register: halve with rounding toward plus infinity, saturate.
    assign hi_i = ($signed({f1_vi_reg[42], f1_vi_reg}) + 44'sd1) >>> 1;
    assign hi_j = ($signed({f1_vj_reg[42], f1_vj_reg}) + 44'sd1) >>> 1;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ci_reg <= f1_sd_reg.calc ? sat44(hi_i) : f1_sd_reg.ci;
            out_cj_reg <= f1_sd_reg.calc ? sat44(hi_j) : f1_sd_reg.cj;
            out_ro_reg <= f1_sd_reg.ro;
            out_st_reg <= f1_sd_reg.status;
        end
    end

    assign m_center_i   = out_ci_reg;
    assign m_center_j   = out_cj_reg;
    assign m_radius_out = out_ro_reg;
    assign m_status     = out_st_reg;

endmodule

// ===== design/arcn_checker.sv =====
// ----------------------------------------------------------------------------
// arcn_checker: port-level checks for arc_center_normalize
// Watches the two channels and the result fields over time; bound to the
// top level below.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arcn_checker import arcn_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_center_i,
    input logic signed [31:0] m_center_j,
    input logic signed [31:0] m_radius_out,
    input logic [1:0]         m_status
);

    // A held result keeps its center_i, radius and status until the transfer.
    `ARCN_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_center_i) && $stable(m_radius_out) && $stable(m_status))

    // The input side stalls only while a result waits at the output.
    `ARCN_ASSERT(a_stall_cause, !s_ready |-> m_valid && !m_ready)

    // Failed radius-mode moves carry a zero center.
    `ARCN_ASSERT(a_fail_zero, m_valid && (m_status == ST_SHORT || m_status == ST_ZERO_CHORD) |-> m_center_i == 0 && m_center_j == 0)

    // Failed radius-mode moves carry a nonnegative radius.
    `ARCN_ASSERT(a_fail_radius, m_valid && (m_status == ST_SHORT || m_status == ST_ZERO_CHORD) |-> !m_radius_out[31])

endmodule

bind arc_center_normalize arcn_checker u_arcn_checker (.*);
